FILE: rtl/tomq_pkg.sv
// shared commands, status codes and cell control type for the ordered message queue
`timescale 1ns / 1ps

package tomq_pkg;

    localparam int STAMP_W   = 64;
    localparam int CMD_W     = 3;
    localparam int STATUS_W  = 2;
    localparam int OUT_CNT_W = 9;
    localparam int PORT_W    = 32;

    localparam logic [CMD_W-1:0] CMD_INSERT   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADV_LT   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ADV_LE   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_TAKE     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_COUNT_LE = 3'd5;
    localparam logic [CMD_W-1:0] CMD_COUNT_LT = 3'd6;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    localparam logic [STAMP_W-1:0] STAMP_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

    // broadcast to every cell in the row
    typedef struct packed {
        logic ins;   // insert the broadcast item
        logic pop;   // shift the row one place towards the head
        logic incl;  // bound test is at-most rather than below
    } t_cell_ctl;

endpackage

FILE: rtl/timestamp_ordered_message_queue_core.sv
// Timestamp-ordered message queue: a row of sorted cells with stable insertion.
// Input channel (i_valid / o_stall) carries a command, a stamp, a source key and
// a payload tag. Output channel (o_valid / i_stall) returns one result item for
// every accepted command: status, changed flag, tally, the taken message, the
// head stamp and the available count after the command.
// Every cell compares its entry with the broadcast stamp in parallel, so each
// command is done at once: the result is registered, shows in the cycle after
// acceptance, and a new item is taken every cycle unless a result is stalled.
// Inserts shift the cells after the insertion point one place to the right,
// takes shift the whole row one place left; leading counts come from the first
// cell that fails the bound.
// The result register parts the two channels; while a result waits under
// i_stall the input stalls and the result holds.
// Reset (synchronous, active low) empties the queue and clears the available
// count at once; cell contents are left as they are and never read while empty.
`timescale 1ns / 1ps

module timestamp_ordered_message_queue_core #(
    parameter int QUEUE_DEPTH = 16,
    parameter int KEY_BITS    = 32,
    parameter int TAG_BITS    = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [tomq_pkg::CMD_W-1:0]           i_command,
    input  logic signed [tomq_pkg::STAMP_W-1:0]  i_stamp,
    input  logic [tomq_pkg::PORT_W-1:0]          i_source_key,
    input  logic [tomq_pkg::PORT_W-1:0]          i_payload_tag,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [tomq_pkg::STATUS_W-1:0]        o_status,
    output logic                                 o_changed,
    output logic [tomq_pkg::OUT_CNT_W-1:0]       o_tally,
    output logic                                 o_msg_valid,
    output logic signed [tomq_pkg::STAMP_W-1:0]  o_msg_stamp,
    output logic [tomq_pkg::PORT_W-1:0]          o_msg_source,
    output logic [tomq_pkg::PORT_W-1:0]          o_msg_tag,
    output logic signed [tomq_pkg::STAMP_W-1:0]  o_head_stamp,
    output logic [tomq_pkg::OUT_CNT_W-1:0]       o_available
);

    localparam int KEY_W = (KEY_BITS < tomq_pkg::PORT_W) ? KEY_BITS : tomq_pkg::PORT_W;
    localparam int TAG_W = (TAG_BITS < tomq_pkg::PORT_W) ? TAG_BITS : tomq_pkg::PORT_W;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

    logic [tomq_pkg::STAMP_W-1:0] w_stamp  [QUEUE_DEPTH];
    logic [KEY_W-1:0]             w_key    [QUEUE_DEPTH];
    logic [TAG_W-1:0]             w_tag    [QUEUE_DEPTH];
    logic [tomq_pkg::STAMP_W-1:0] w_nxt_stamp [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0]       w_open, w_pred, w_boundary;

    logic [CNT_W-1:0] r_fill, n_fill;
    logic [CNT_W-1:0] r_ready, n_ready;
    logic             r_out_valid;

    logic [tomq_pkg::STATUS_W-1:0]  r_status, n_status;
    logic                           r_changed, n_changed;
    logic [CNT_W-1:0]               r_tally, n_tally;
    logic                           r_msg_valid, n_msg_valid;
    logic [tomq_pkg::STAMP_W-1:0]   r_msg_stamp, n_msg_stamp;
    logic [KEY_W-1:0]               r_msg_source, n_msg_source;
    logic [TAG_W-1:0]               r_msg_tag, n_msg_tag;
    logic [tomq_pkg::STAMP_W-1:0]   r_head, n_head;

    tomq_pkg::t_cell_ctl w_ctl;
    logic             w_accept;
    logic             w_full;
    logic             w_take_ok;
    logic [CNT_W-1:0] w_lead;
    logic [KEY_W-1:0] w_key_in;
    logic [TAG_W-1:0] w_tag_in;

    assign o_stall  = r_out_valid & i_stall;
    assign w_accept = i_valid & ~o_stall;
    assign w_key_in = i_source_key[KEY_W-1:0];
    assign w_tag_in = i_payload_tag[TAG_W-1:0];

    assign w_full    = r_fill == DEPTH_C;
    assign w_take_ok = (r_ready != '0) & (r_fill != '0) &
                       ~($signed(i_stamp) < $signed(w_stamp[0]));

    assign w_ctl.ins  = w_accept & (i_command == tomq_pkg::CMD_INSERT) & ~w_full;
    assign w_ctl.pop  = w_accept & (i_command == tomq_pkg::CMD_TAKE) & w_take_ok;
    assign w_ctl.incl = (i_command == tomq_pkg::CMD_ADV_LE) ||
                        (i_command == tomq_pkg::CMD_COUNT_LE);

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            logic                         w_l_open;
            logic [tomq_pkg::STAMP_W-1:0] w_l_stamp, w_r_stamp;
            logic [KEY_W-1:0]             w_l_key, w_r_key;
            logic [TAG_W-1:0]             w_l_tag, w_r_tag;
            logic                         w_r_pred;

            if (g == 0) begin : g_head
                assign w_l_open  = 1'b0;
                assign w_l_stamp = '0;
                assign w_l_key   = '0;
                assign w_l_tag   = '0;
            end else begin : g_mid
                assign w_l_open  = w_open[g-1];
                assign w_l_stamp = w_stamp[g-1];
                assign w_l_key   = w_key[g-1];
                assign w_l_tag   = w_tag[g-1];
            end

            if (g == QUEUE_DEPTH - 1) begin : g_tail
                assign w_r_pred  = 1'b0;
                assign w_r_stamp = '0;
                assign w_r_key   = '0;
                assign w_r_tag   = '0;
            end else begin : g_body
                assign w_r_pred  = w_pred[g+1];
                assign w_r_stamp = w_stamp[g+1];
                assign w_r_key   = w_key[g+1];
                assign w_r_tag   = w_tag[g+1];
            end

            tomq_cell #(
                .IDX   (g),
                .KEY_W (KEY_W),
                .TAG_W (TAG_W),
                .CNT_W (CNT_W)
            ) u_cell (
                .i_clk         (i_clk),
                .i_ctl         (w_ctl),
                .i_fill        (r_fill),
                .i_stamp       (i_stamp),
                .i_key         (w_key_in),
                .i_tag         (w_tag_in),
                .i_left_open   (w_l_open),
                .i_left_stamp  (w_l_stamp),
                .i_left_key    (w_l_key),
                .i_left_tag    (w_l_tag),
                .i_right_pred  (w_r_pred),
                .i_right_stamp (w_r_stamp),
                .i_right_key   (w_r_key),
                .i_right_tag   (w_r_tag),
                .o_open        (w_open[g]),
                .o_pred        (w_pred[g]),
                .o_boundary    (w_boundary[g]),
                .o_stamp       (w_stamp[g]),
                .o_key         (w_key[g]),
                .o_tag         (w_tag[g]),
                .o_nxt_stamp   (w_nxt_stamp[g])
            );
        end
    endgenerate

    // at most one boundary cell, so the run length is a one-hot or
    always_comb begin
        w_lead = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            w_lead = w_lead | (w_boundary[i] ? CNT_W'(i + 1) : '0);
        end
    end

    always_comb begin
        n_fill       = r_fill;
        n_ready      = r_ready;
        n_status     = tomq_pkg::ST_OK;
        n_changed    = 1'b0;
        n_tally      = '0;
        n_msg_valid  = 1'b0;
        n_msg_stamp  = '0;
        n_msg_source = '0;
        n_msg_tag    = '0;
        case (i_command)
            tomq_pkg::CMD_INSERT: begin
                if (w_full) begin
                    n_status = tomq_pkg::ST_FULL;
                end else begin
                    n_fill = r_fill + 1'b1;
                end
            end
            tomq_pkg::CMD_ADV_LT, tomq_pkg::CMD_ADV_LE: begin
                n_ready   = w_lead;
                n_changed = w_lead != r_ready;
            end
            tomq_pkg::CMD_TAKE: begin
                if (w_take_ok) begin
                    n_msg_valid  = 1'b1;
                    n_msg_stamp  = w_stamp[0];
                    n_msg_source = w_key[0];
                    n_msg_tag    = w_tag[0];
                    n_fill       = r_fill - 1'b1;
                    n_ready      = r_ready - 1'b1;
                end else begin
                    n_status = tomq_pkg::ST_EMPTY;
                end
            end
            tomq_pkg::CMD_CLEAR: begin
                n_fill  = '0;
                n_ready = '0;
            end
            tomq_pkg::CMD_COUNT_LE, tomq_pkg::CMD_COUNT_LT: begin
                n_tally = w_lead;
            end
            default: begin
            end
        endcase
        n_head = (n_fill != '0) ? w_nxt_stamp[0] : tomq_pkg::STAMP_MAX;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_ready     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_fill  <= n_fill;
                r_ready <= n_ready;
            end
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status     <= n_status;
            r_changed    <= n_changed;
            r_tally      <= n_tally;
            r_msg_valid  <= n_msg_valid;
            r_msg_stamp  <= n_msg_stamp;
            r_msg_source <= n_msg_source;
            r_msg_tag    <= n_msg_tag;
            r_head       <= n_head;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_status;
    assign o_changed    = r_changed;
    assign o_tally      = tomq_pkg::OUT_CNT_W'(r_tally);
    assign o_msg_valid  = r_msg_valid;
    assign o_msg_stamp  = r_msg_stamp;
    assign o_msg_source = tomq_pkg::PORT_W'(r_msg_source);
    assign o_msg_tag    = tomq_pkg::PORT_W'(r_msg_tag);
    assign o_head_stamp = r_head;
    assign o_available  = tomq_pkg::OUT_CNT_W'(r_ready);

    a_ready_le_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ready <= r_fill)
        else $error("available count exceeds fill level");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= DEPTH_C)
        else $error("fill level beyond queue depth");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.ins |=> (r_fill == $past(r_fill) + 1'b1) && o_valid && !o_msg_valid)
        else $error("insert did not grow the queue by one");

    a_pop_reports: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.pop |=> o_msg_valid && (o_status == tomq_pkg::ST_OK) &&
                      (r_fill == $past(r_fill) - 1'b1))
        else $error("take shifted the row without returning an item");

    a_single_boundary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_boundary))
        else $error("leading run has more than one end");

endmodule

FILE: rtl/tomq_cell.sv
// one storage cell of the sorted queue row
`timescale 1ns / 1ps

module tomq_cell #(
    parameter int IDX   = 0,
    parameter int KEY_W = 32,
    parameter int TAG_W = 32,
    parameter int CNT_W = 5
) (
    input  logic                             i_clk,
    input  tomq_pkg::t_cell_ctl              i_ctl,
    input  logic [CNT_W-1:0]                 i_fill,
    input  logic [tomq_pkg::STAMP_W-1:0]     i_stamp,
    input  logic [KEY_W-1:0]                 i_key,
    input  logic [TAG_W-1:0]                 i_tag,
    input  logic                             i_left_open,
    input  logic [tomq_pkg::STAMP_W-1:0]     i_left_stamp,
    input  logic [KEY_W-1:0]                 i_left_key,
    input  logic [TAG_W-1:0]                 i_left_tag,
    input  logic                             i_right_pred,
    input  logic [tomq_pkg::STAMP_W-1:0]     i_right_stamp,
    input  logic [KEY_W-1:0]                 i_right_key,
    input  logic [TAG_W-1:0]                 i_right_tag,
    output logic                             o_open,
    output logic                             o_pred,
    output logic                             o_boundary,
    output logic [tomq_pkg::STAMP_W-1:0]     o_stamp,
    output logic [KEY_W-1:0]                 o_key,
    output logic [TAG_W-1:0]                 o_tag,
    output logic [tomq_pkg::STAMP_W-1:0]     o_nxt_stamp
);

    localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

    logic [tomq_pkg::STAMP_W-1:0] r_stamp, n_stamp;
    logic [KEY_W-1:0]             r_key, n_key;
    logic [TAG_W-1:0]             r_tag, n_tag;

    logic w_valid;
    logic w_in_lt;   // broadcast stamp below stored stamp
    logic w_st_lt;   // stored stamp below broadcast stamp
    logic w_greater;

    assign w_valid   = i_fill > IDX_C;
    assign w_in_lt   = $signed(i_stamp) < $signed(r_stamp);
    assign w_st_lt   = $signed(r_stamp) < $signed(i_stamp);
    // stored entry sorts after the new one: equal pairs stay ahead
    assign w_greater = w_valid & (w_in_lt | ((i_stamp == r_stamp) & (r_key > i_key)));
    assign o_open    = w_greater | ~w_valid;
    assign o_pred    = w_valid & (i_ctl.incl ? ~w_in_lt : w_st_lt);
    // last cell of the leading run that meets the bound
    assign o_boundary = o_pred & ~i_right_pred;

    always_comb begin
        n_stamp = r_stamp;
        n_key   = r_key;
        n_tag   = r_tag;
        if (i_ctl.ins) begin
            if (i_left_open) begin
                n_stamp = i_left_stamp;
                n_key   = i_left_key;
                n_tag   = i_left_tag;
            end else if (o_open) begin
                n_stamp = i_stamp;
                n_key   = i_key;
                n_tag   = i_tag;
            end
        end else if (i_ctl.pop) begin
            n_stamp = i_right_stamp;
            n_key   = i_right_key;
            n_tag   = i_right_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_stamp <= n_stamp;
        r_key   <= n_key;
        r_tag   <= n_tag;
    end

    assign o_stamp     = r_stamp;
    assign o_key       = r_key;
    assign o_tag       = r_tag;
    assign o_nxt_stamp = n_stamp;

endmodule

FILE: dv/tomq_order_checker.sv
// checker for the ordered message queue: watches both channels, predicts and compares results
`timescale 1ns / 1ps

module tomq_order_checker #(
    parameter int QUEUE_DEPTH = 16,
    parameter int KEY_BITS    = 32,
    parameter int TAG_BITS    = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cmd_valid,
    input  logic                                 i_cmd_stall,
    input  logic [tomq_pkg::CMD_W-1:0]           i_command,
    input  logic signed [tomq_pkg::STAMP_W-1:0]  i_stamp,
    input  logic [tomq_pkg::PORT_W-1:0]          i_source_key,
    input  logic [tomq_pkg::PORT_W-1:0]          i_payload_tag,
    input  logic                                 i_res_valid,
    input  logic                                 i_res_stall,
    input  logic [tomq_pkg::STATUS_W-1:0]        i_status,
    input  logic                                 i_changed,
    input  logic [tomq_pkg::OUT_CNT_W-1:0]       i_tally,
    input  logic                                 i_msg_valid,
    input  logic signed [tomq_pkg::STAMP_W-1:0]  i_msg_stamp,
    input  logic [tomq_pkg::PORT_W-1:0]          i_msg_source,
    input  logic [tomq_pkg::PORT_W-1:0]          i_msg_tag,
    input  logic signed [tomq_pkg::STAMP_W-1:0]  i_head_stamp,
    input  logic [tomq_pkg::OUT_CNT_W-1:0]       i_available,
    output int                                   o_fail_count,
    output int                                   o_pending
);

    typedef struct packed {
        logic [tomq_pkg::STATUS_W-1:0]  status;
        logic                           changed;
        logic [tomq_pkg::OUT_CNT_W-1:0] tally;
        logic                           msg_valid;
        logic [tomq_pkg::STAMP_W-1:0]   msg_stamp;
        logic [tomq_pkg::PORT_W-1:0]    msg_source;
        logic [tomq_pkg::PORT_W-1:0]    msg_tag;
        logic [tomq_pkg::STAMP_W-1:0]   head_stamp;
        logic [tomq_pkg::OUT_CNT_W-1:0] available;
    } t_outcome;

    localparam logic [tomq_pkg::PORT_W-1:0] KEY_MASK =
        KEY_BITS >= tomq_pkg::PORT_W ? '1 : tomq_pkg::PORT_W'((64'd1 << KEY_BITS) - 1);
    localparam logic [tomq_pkg::PORT_W-1:0] TAG_MASK =
        TAG_BITS >= tomq_pkg::PORT_W ? '1 : tomq_pkg::PORT_W'((64'd1 << TAG_BITS) - 1);

    // sorted copy of the queue, head at index 0
    logic signed [tomq_pkg::STAMP_W-1:0] cell_stamp  [QUEUE_DEPTH];
    logic [tomq_pkg::PORT_W-1:0]         cell_source [QUEUE_DEPTH];
    logic [tomq_pkg::PORT_W-1:0]         cell_tag    [QUEUE_DEPTH];
    int fill  = 0;
    int ready = 0;

    t_outcome due_results [$];
    int n_taken   = 0;
    int n_checked = 0;
    int fails     = 0;

    assign o_pending    = n_taken - n_checked;
    assign o_fail_count = fails;

    function automatic int leading_ready(logic signed [tomq_pkg::STAMP_W-1:0] bound, bit incl);
        int n;
        n = 0;
        while (n < fill && (incl ? cell_stamp[n] <= bound : cell_stamp[n] < bound))
            n++;
        return n;
    endfunction

    function automatic t_outcome apply_command(logic [tomq_pkg::CMD_W-1:0] cmd,
                                               logic signed [tomq_pkg::STAMP_W-1:0] stamp,
                                               logic [tomq_pkg::PORT_W-1:0] key,
                                               logic [tomq_pkg::PORT_W-1:0] tag);
        t_outcome r;
        int pos;
        r = '0;
        case (cmd)
            tomq_pkg::CMD_INSERT: begin
                if (fill >= QUEUE_DEPTH) begin
                    r.status = tomq_pkg::ST_FULL;
                end else begin
                    // goes after every entry with an equal stamp and key
                    pos = 0;
                    while (pos < fill && !(stamp < cell_stamp[pos] ||
                           (stamp == cell_stamp[pos] && cell_source[pos] > key)))
                        pos++;
                    for (int i = fill; i > pos; i--) begin
                        cell_stamp[i]  = cell_stamp[i-1];
                        cell_source[i] = cell_source[i-1];
                        cell_tag[i]    = cell_tag[i-1];
                    end
                    cell_stamp[pos]  = stamp;
                    cell_source[pos] = key;
                    cell_tag[pos]    = tag;
                    fill++;
                end
            end
            tomq_pkg::CMD_ADV_LT, tomq_pkg::CMD_ADV_LE: begin
                pos = leading_ready(stamp, cmd == tomq_pkg::CMD_ADV_LE);
                if (pos != ready) begin
                    ready     = pos;
                    r.changed = 1'b1;
                end
            end
            tomq_pkg::CMD_TAKE: begin
                if (ready > 0 && fill > 0 && cell_stamp[0] <= stamp) begin
                    r.msg_valid  = 1'b1;
                    r.msg_stamp  = cell_stamp[0];
                    r.msg_source = cell_source[0];
                    r.msg_tag    = cell_tag[0];
                    for (int i = 1; i < fill; i++) begin
                        cell_stamp[i-1]  = cell_stamp[i];
                        cell_source[i-1] = cell_source[i];
                        cell_tag[i-1]    = cell_tag[i];
                    end
                    fill--;
                    ready--;
                end else begin
                    r.status = tomq_pkg::ST_EMPTY;
                end
            end
            tomq_pkg::CMD_CLEAR: begin
                fill  = 0;
                ready = 0;
            end
            tomq_pkg::CMD_COUNT_LE, tomq_pkg::CMD_COUNT_LT: begin
                r.tally = tomq_pkg::OUT_CNT_W'(leading_ready(stamp,
                                                             cmd == tomq_pkg::CMD_COUNT_LE));
            end
            default: ;
        endcase
        r.head_stamp = fill > 0 ? cell_stamp[0] : tomq_pkg::STAMP_MAX;
        r.available  = tomq_pkg::OUT_CNT_W'(ready);
        return r;
    endfunction

    task automatic report(string what);
        $display("tomq check @%0t: %s", $time, what);
        fails++;
    endtask

    task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
        if (got !== want)
            report($sformatf("%s got %h want %h", name, got, want));
    endtask

    always @(posedge i_clk) begin : watch
        t_outcome want;
        t_outcome fresh;
        if (!i_rst_n) begin
            fill  = 0;
            ready = 0;
            due_results.delete();
            n_taken   <= 0;
            n_checked <= 0;
        end else begin
            // check first: the item accepted at this edge cannot be answered yet
            if (i_res_valid && !i_res_stall) begin
                n_checked <= n_checked + 1;
                if (due_results.size() == 0) begin
                    report("result item with none expected");
                end else begin
                    want = due_results[0];
                    due_results.delete(0);
                    check_field("status",     i_status,     want.status);
                    check_field("changed",    i_changed,    want.changed);
                    check_field("tally",      i_tally,      want.tally);
                    check_field("msg_valid",  i_msg_valid,  want.msg_valid);
                    check_field("msg_stamp",  i_msg_stamp,  want.msg_stamp);
                    check_field("msg_source", i_msg_source, want.msg_source);
                    check_field("msg_tag",    i_msg_tag,    want.msg_tag);
                    check_field("head_stamp", i_head_stamp, want.head_stamp);
                    check_field("available",  i_available,  want.available);
                end
            end
            if (i_cmd_valid && !i_cmd_stall) begin
                fresh = apply_command(i_command, i_stamp,
                                      i_source_key & KEY_MASK,
                                      i_payload_tag & TAG_MASK);
                due_results.insert(due_results.size(), fresh);
                n_taken <= n_taken + 1;
            end
        end
    end

endmodule

FILE: dv/timestamp_ordered_message_queue_core_tb.sv
// testbench top for the ordered message queue: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module timestamp_ordered_message_queue_core_tb;

    localparam int DEPTH       = 16;
    localparam int KEY_BITS    = 32;
    localparam int TAG_BITS    = 32;
    localparam int RAND_ITEMS  = 1900;
    localparam int IDLE_LIMIT  = 3000;
    localparam int HOLD_AT     = 500;
    localparam int HOLD_CYCLES = 400;

    localparam logic [tomq_pkg::CMD_W-1:0]          CMD_UNUSED = 3'd7;
    localparam logic signed [tomq_pkg::STAMP_W-1:0] STAMP_MIN  = 64'sh8000_0000_0000_0000;
    localparam logic signed [tomq_pkg::STAMP_W-1:0] STAMP_TOP  = tomq_pkg::STAMP_MAX;

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n;
    logic                                 i_valid;
    logic                                 o_stall;
    logic [tomq_pkg::CMD_W-1:0]           i_command;
    logic signed [tomq_pkg::STAMP_W-1:0]  i_stamp;
    logic [tomq_pkg::PORT_W-1:0]          i_source_key;
    logic [tomq_pkg::PORT_W-1:0]          i_payload_tag;
    logic                                 o_valid;
    logic                                 i_stall;
    logic [tomq_pkg::STATUS_W-1:0]        o_status;
    logic                                 o_changed;
    logic [tomq_pkg::OUT_CNT_W-1:0]       o_tally;
    logic                                 o_msg_valid;
    logic signed [tomq_pkg::STAMP_W-1:0]  o_msg_stamp;
    logic [tomq_pkg::PORT_W-1:0]          o_msg_source;
    logic [tomq_pkg::PORT_W-1:0]          o_msg_tag;
    logic signed [tomq_pkg::STAMP_W-1:0]  o_head_stamp;
    logic [tomq_pkg::OUT_CNT_W-1:0]       o_available;

    int fail_count;
    int pending;
    int idle_cycles = 0;
    bit quiet_send  = 1'b0;
    bit quiet_recv  = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    timestamp_ordered_message_queue_core #(
        .QUEUE_DEPTH (DEPTH),
        .KEY_BITS    (KEY_BITS),
        .TAG_BITS    (TAG_BITS)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_command     (i_command),
        .i_stamp       (i_stamp),
        .i_source_key  (i_source_key),
        .i_payload_tag (i_payload_tag),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_changed     (o_changed),
        .o_tally       (o_tally),
        .o_msg_valid   (o_msg_valid),
        .o_msg_stamp   (o_msg_stamp),
        .o_msg_source  (o_msg_source),
        .o_msg_tag     (o_msg_tag),
        .o_head_stamp  (o_head_stamp),
        .o_available   (o_available)
    );

    tomq_order_checker #(
        .QUEUE_DEPTH (DEPTH),
        .KEY_BITS    (KEY_BITS),
        .TAG_BITS    (TAG_BITS)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (i_valid),
        .i_cmd_stall   (o_stall),
        .i_command     (i_command),
        .i_stamp       (i_stamp),
        .i_source_key  (i_source_key),
        .i_payload_tag (i_payload_tag),
        .i_res_valid   (o_valid),
        .i_res_stall   (i_stall),
        .i_status      (o_status),
        .i_changed     (o_changed),
        .i_tally       (o_tally),
        .i_msg_valid   (o_msg_valid),
        .i_msg_stamp   (o_msg_stamp),
        .i_msg_source  (o_msg_source),
        .i_msg_tag     (o_msg_tag),
        .i_head_stamp  (o_head_stamp),
        .i_available   (o_available),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // message times: extremes, full-width values, and a narrow band so that ties happen
    function automatic logic signed [tomq_pkg::STAMP_W-1:0] rand_stamp();
        int v;
        v = $urandom_range(0, 16);
        case ($urandom_range(0, 9))
            0:       return STAMP_MIN;
            1:       return STAMP_TOP;
            2, 3:    return {$urandom, $urandom};
            default: return v - 8;
        endcase
    endfunction

    // bounds lean towards the top so that advances and takes reach deep into the queue
    function automatic logic signed [tomq_pkg::STAMP_W-1:0] rand_bound();
        if ($urandom_range(0, 9) < 3)
            return STAMP_TOP;
        return rand_stamp();
    endfunction

    function automatic logic [tomq_pkg::PORT_W-1:0] rand_key();
        case ($urandom_range(0, 7))
            0:       return '1;
            1:       return $urandom;
            default: return $urandom_range(0, 3);
        endcase
    endfunction

    // kind 0 fills the queue, kind 1 drains it, kind 2 is a mix
    function automatic logic [tomq_pkg::CMD_W-1:0] pick_command(int kind);
        int ins_pct;
        int r;
        ins_pct = kind == 0 ? 70 : kind == 1 ? 10 : 35;
        if ($urandom_range(0, 99) < ins_pct)
            return tomq_pkg::CMD_INSERT;
        r = $urandom_range(0, 99);
        if (r < 34) return tomq_pkg::CMD_TAKE;
        if (r < 56) return tomq_pkg::CMD_ADV_LE;
        if (r < 68) return tomq_pkg::CMD_ADV_LT;
        if (r < 80) return tomq_pkg::CMD_COUNT_LE;
        if (r < 92) return tomq_pkg::CMD_COUNT_LT;
        if (r < 96) return tomq_pkg::CMD_CLEAR;
        return CMD_UNUSED;
    endfunction

    task automatic send_item(input logic [tomq_pkg::CMD_W-1:0] cmd,
                             input logic signed [tomq_pkg::STAMP_W-1:0] stamp,
                             input logic [tomq_pkg::PORT_W-1:0] key,
                             input logic [tomq_pkg::PORT_W-1:0] tag);
        int gap;
        gap = quiet_send ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_command     <= cmd;
        i_stamp       <= stamp;
        i_source_key  <= key;
        i_payload_tag <= tag;
        i_valid       <= 1'b1;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin : stimulus
        int n;
        int kind;
        int len;
        bit paused;
        logic [tomq_pkg::CMD_W-1:0] cmd;
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_command     <= tomq_pkg::CMD_INSERT;
        i_stamp       <= '0;
        i_source_key  <= '0;
        i_payload_tag <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_item(CMD_UNUSED,             $urandom,   $urandom, $urandom);
        send_item(tomq_pkg::CMD_TAKE,     STAMP_TOP,  0, 0);      // empty queue
        send_item(tomq_pkg::CMD_INSERT,   STAMP_MIN,  '1, '1);
        send_item(tomq_pkg::CMD_INSERT,   STAMP_TOP,  0, 0);
        send_item(tomq_pkg::CMD_INSERT,   0,          5, 32'hA);
        send_item(tomq_pkg::CMD_INSERT,   0,          5, 32'hB);  // equal key keeps arrival order
        send_item(tomq_pkg::CMD_INSERT,   0,          3, 32'hC);  // smaller key goes first
        send_item(tomq_pkg::CMD_COUNT_LE, 0,          0, 0);
        send_item(tomq_pkg::CMD_COUNT_LT, 0,          0, 0);
        send_item(tomq_pkg::CMD_COUNT_LE, STAMP_TOP,  0, 0);
        send_item(tomq_pkg::CMD_COUNT_LT, STAMP_MIN,  0, 0);
        send_item(tomq_pkg::CMD_TAKE,     STAMP_TOP,  0, 0);      // nothing available yet
        send_item(tomq_pkg::CMD_ADV_LT,   0,          0, 0);
        send_item(tomq_pkg::CMD_ADV_LT,   0,          0, 0);      // no change
        send_item(tomq_pkg::CMD_TAKE,     STAMP_MIN,  0, 0);
        send_item(tomq_pkg::CMD_ADV_LE,   0,          0, 0);
        send_item(tomq_pkg::CMD_TAKE,     -1,         0, 0);      // head later than the bound
        send_item(tomq_pkg::CMD_TAKE,     0,          0, 0);
        send_item(tomq_pkg::CMD_TAKE,     0,          0, 0);
        send_item(tomq_pkg::CMD_TAKE,     STAMP_TOP,  0, 0);
        send_item(tomq_pkg::CMD_TAKE,     STAMP_TOP,  0, 0);      // count used up
        send_item(tomq_pkg::CMD_ADV_LE,   STAMP_TOP,  0, 0);
        send_item(tomq_pkg::CMD_CLEAR,    0,          0, 0);
        send_item(tomq_pkg::CMD_TAKE,     STAMP_TOP,  0, 0);
        wait_drained();

        n = 0;
        paused = 1'b0;
        while (n < RAND_ITEMS) begin
            kind = $urandom_range(0, 2);
            len = $urandom_range(20, 80);
            quiet_send = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < len && n < RAND_ITEMS; k++) begin
                cmd = pick_command(kind);
                send_item(cmd, cmd == tomq_pkg::CMD_INSERT ? rand_stamp() : rand_bound(),
                          rand_key(), $urandom);
                n++;
            end
            if ((!paused && n >= RAND_ITEMS / 2) || $urandom_range(0, 5) == 0) begin
                wait_drained();
                paused = 1'b1;
            end
        end

        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
        if (fail_count == 0)
            $display("timestamp_ordered_message_queue_core: match");
        else
            $display("timestamp_ordered_message_queue_core: mismatch");
        $finish;
    end

    initial begin : receiver
        int wait_n;
        int taken;
        taken = 0;
        i_stall <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (taken % 60 == 0)
                quiet_recv = ($urandom_range(0, 3) == 0);
            // one long hold-off lets the block back up into its input
            wait_n = taken == HOLD_AT ? HOLD_CYCLES : quiet_recv ? 0 : $urandom_range(0, 13);
            if (wait_n > 0) begin
                i_stall <= 1'b1;
                repeat (wait_n) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
            taken++;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("timestamp_ordered_message_queue_core: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
